[src/etf_pkg.sv]
// etf_pkg: shared types, constants and table functions of the epoch time formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package etf_pkg;

    localparam int RUN_MAX    = 24;
    localparam int LEN_W      = $clog2(RUN_MAX + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_PCT = "%";

    localparam logic [23:0][7:0] ZERO_TEXT = "Thu Jan  1 00:00:00 1970";

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_SPEC = 2'd1,
        CMD_ZERO = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } cmd_t;

    // Two ASCII digits, index 0 is the tens digit (printed first).
    typedef logic [1:0][7:0] pair_t;

    typedef struct packed {
        pair_t      yr_hi;
        pair_t      yr_lo;
        pair_t      mon;
        pair_t      mday;
        pair_t      hour;
        pair_t      min;
        pair_t      sec;
        pair_t      h12;
        logic [7:0] yday_h;
        pair_t      yday_lo;
        logic [2:0] wday;
        logic [3:0] mon_idx;
        logic       pm;
    } civil_t;

    // Name padded with spaces, first character in the top byte.
    typedef struct packed {
        logic [8:0][7:0] txt;
        logic [3:0]      len;
    } name_t;

    // Value below 100 to two ASCII digits; tens by reciprocal multiply.
    function automatic pair_t dec2(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  u;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        u    = v - 7'(7'(tens) * 7'd10);
        dec2[0] = 8'h30 + 8'(tens);
        dec2[1] = 8'h30 + 8'(u[3:0]);
    endfunction

    // Days before the first of the month, non-leap year; month 1..12.
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        case (month)
            4'd1:    cum_days = 9'd0;
            4'd2:    cum_days = 9'd31;
            4'd3:    cum_days = 9'd59;
            4'd4:    cum_days = 9'd90;
            4'd5:    cum_days = 9'd120;
            4'd6:    cum_days = 9'd151;
            4'd7:    cum_days = 9'd181;
            4'd8:    cum_days = 9'd212;
            4'd9:    cum_days = 9'd243;
            4'd10:   cum_days = 9'd273;
            4'd11:   cum_days = 9'd304;
            4'd12:   cum_days = 9'd334;
            default: cum_days = 9'd0;
        endcase
    endfunction

    function automatic name_t day_name(input logic [2:0] wd);
        case (wd)
            3'd0:    day_name = '{txt: "Sunday   ", len: 4'd6};
            3'd1:    day_name = '{txt: "Monday   ", len: 4'd6};
            3'd2:    day_name = '{txt: "Tuesday  ", len: 4'd7};
            3'd3:    day_name = '{txt: "Wednesday", len: 4'd9};
            3'd4:    day_name = '{txt: "Thursday ", len: 4'd8};
            3'd5:    day_name = '{txt: "Friday   ", len: 4'd6};
            3'd6:    day_name = '{txt: "Saturday ", len: 4'd8};
            default: day_name = '{txt: "Sunday   ", len: 4'd6};
        endcase
    endfunction

    function automatic name_t mon_name(input logic [3:0] mi);
        case (mi)
            4'd0:    mon_name = '{txt: "January  ", len: 4'd7};
            4'd1:    mon_name = '{txt: "February ", len: 4'd8};
            4'd2:    mon_name = '{txt: "March    ", len: 4'd5};
            4'd3:    mon_name = '{txt: "April    ", len: 4'd5};
            4'd4:    mon_name = '{txt: "May      ", len: 4'd3};
            4'd5:    mon_name = '{txt: "June     ", len: 4'd4};
            4'd6:    mon_name = '{txt: "July     ", len: 4'd4};
            4'd7:    mon_name = '{txt: "August   ", len: 4'd6};
            4'd8:    mon_name = '{txt: "September", len: 4'd9};
            4'd9:    mon_name = '{txt: "October  ", len: 4'd7};
            4'd10:   mon_name = '{txt: "November ", len: 4'd8};
            4'd11:   mon_name = '{txt: "December ", len: 4'd8};
            default: mon_name = '{txt: "January  ", len: 4'd7};
        endcase
    endfunction

endpackage

[src/etf_civil.sv]
// etf_civil: holds the epoch register and converts it to calendar fields.
// Days-to-civil steps run through the DAYS to PACK states using reciprocal multiplies. Uses etf_pkg.
`timescale 1ns / 1ps
module etf_civil
    import etf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    output logic        cfg_ready,
    output logic        busy,
    output logic        epoch_zero,
    output civil_t      civil
);

    typedef enum logic [12:0] {
        CV_IDLE  = 13'b0000000000001,
        CV_DAYS  = 13'b0000000000010,
        CV_SPLIT = 13'b0000000000100,
        CV_DIV1  = 13'b0000000001000,
        CV_YOE   = 13'b0000000010000,
        CV_DOY   = 13'b0000000100000,
        CV_MP    = 13'b0000001000000,
        CV_MDAY  = 13'b0000010000000,
        CV_YEAR  = 13'b0000100000000,
        CV_Y100  = 13'b0001000000000,
        CV_YR    = 13'b0010000000000,
        CV_YDAY  = 13'b0100000000000,
        CV_PACK  = 13'b1000000000000
    } cv_state_t;

    cv_state_t   state_reg, state_next;
    logic [31:0] epoch_reg, epoch_next;

    logic [15:0] days_reg;
    logic [16:0] secs_reg;
    logic [12:0] wq_reg;
    logic [4:0]  hour_reg;
    logic [11:0] t_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [2:0]  wday_reg;
    logic [2:0]  era_reg;
    logic [17:0] doe_reg;
    logic [6:0]  a_reg;
    logic [2:0]  b_reg;
    logic        c_reg;
    logic [8:0]  yoe_reg;
    logic [8:0]  doy_reg;
    logic [3:0]  mp_reg;
    logic [4:0]  mday_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;
    logic [4:0]  yq100_reg;
    logic [6:0]  yr100_reg;
    logic [8:0]  yday1_reg;
    logic [3:0]  h12_reg;
    civil_t      civil_reg;

    // floor(x / d) as (x * m) >> k; m and k are exact over each operand's range
    logic [50:0] days_prod;     // (ts >> 7) / 675, k = 35
    logic [31:0] secs_full;
    logic [19:0] z_val;
    logic        era5;
    logic [19:0] doe_full;
    logic [16:0] day4;
    logic [31:0] wq_prod;       // (days + 4) / 7, k = 19
    logic [24:0] hour_prod;     // (secs >> 4) / 225, k = 20
    logic [16:0] wday_full;
    logic [30:0] a_prod;        // (doe >> 2) / 365, k = 24
    logic [2:0]  b_calc;
    logic [16:0] t_full;
    logic [17:0] yoe_num;
    logic [32:0] yoe_prod;      // / 365, k = 24
    logic [19:0] min_prod;      // (t >> 2) / 15, k = 14
    logic [1:0]  yoe_hund;
    logic [17:0] doy_full;
    logic [11:0] sec_full;
    logic [10:0] mp_num;
    logic [21:0] mp_prod;       // / 153, k = 18
    logic [10:0] f_num;
    logic [21:0] f_prod;        // / 5, k = 13
    logic [8:0]  mday_full;
    logic [11:0] year_calc;
    logic [19:0] yq_prod;       // (year >> 2) / 25, k = 15
    logic [11:0] yr_full;
    logic        leap;
    logic        cfg_take;

    assign cfg_ready  = (state_reg == CV_IDLE);
    assign busy       = (state_reg != CV_IDLE);
    assign epoch_zero = (epoch_reg == 32'd0);
    assign civil      = civil_reg;
    assign cfg_take   = cfg_valid && cfg_ready;

    assign days_prod = 51'(epoch_reg[31:7]) * 51'd50903317;
    assign secs_full = epoch_reg - 32'(days_reg) * 32'd86400;
    // era is 4 or 5 for any 32-bit count
    assign z_val     = 20'(days_reg) + 20'd719468;
    assign era5      = (z_val >= 20'd730485);
    assign doe_full  = z_val - (era5 ? 20'd730485 : 20'd584388);
    assign day4      = 17'(days_reg) + 17'd4;
    assign wq_prod   = 32'(day4) * 32'd74899;
    assign hour_prod = 25'(secs_reg[16:4]) * 25'd4661;
    assign wday_full = day4 - 17'(wq_reg) * 17'd7;
    assign a_prod    = 31'(doe_reg[17:2]) * 31'd45965;
    assign b_calc    = (doe_reg >= 18'd146096) ? 3'd4 :
                       (doe_reg >= 18'd109572) ? 3'd3 :
                       (doe_reg >= 18'd73048)  ? 3'd2 :
                       (doe_reg >= 18'd36524)  ? 3'd1 : 3'd0;
    assign t_full    = secs_reg - 17'(hour_reg) * 17'd3600;
    assign yoe_num   = doe_reg - 18'(a_reg) + 18'(b_reg) - 18'(c_reg);
    assign yoe_prod  = 33'(yoe_num) * 33'd45965;
    assign min_prod  = 20'(t_reg[11:2]) * 20'd1093;
    assign yoe_hund  = (yoe_reg >= 9'd300) ? 2'd3 :
                       (yoe_reg >= 9'd200) ? 2'd2 :
                       (yoe_reg >= 9'd100) ? 2'd1 : 2'd0;
    // doy = doe - (365*yoe + yoe/4 - yoe/100)
    assign doy_full  = doe_reg - (18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) - 18'(yoe_hund));
    assign sec_full  = t_reg - 12'(min_reg) * 12'd60;
    assign mp_num    = 11'(doy_reg) * 11'd5 + 11'd2;
    assign mp_prod   = 22'(mp_num) * 22'd1714;
    assign f_num     = 11'(mp_reg) * 11'd153 + 11'd2;
    assign f_prod    = 22'(f_num) * 22'd1639;
    assign mday_full = doy_reg - f_prod[21:13] + 9'd1;
    assign year_calc = 12'(yoe_reg) + 12'(era_reg) * 12'd400
                     + ((month_reg <= 4'd2) ? 12'd1 : 12'd0);
    assign yq_prod   = 20'(year_reg[11:2]) * 20'd1311;
    assign yr_full   = year_reg - 12'(yq100_reg) * 12'd100;
    // divisible by 400: remainder by 100 is zero and the hundreds are a multiple of 4
    assign leap      = ((year_reg[1:0] == 2'd0) && (yr100_reg != 7'd0))
                     || ((yr100_reg == 7'd0) && (yq100_reg[1:0] == 2'd0));

    always_comb begin
        state_next = state_reg;
        epoch_next = epoch_reg;
        case (state_reg)
            CV_IDLE: begin
                if (cfg_take) begin
                    epoch_next = cfg_data;
                    state_next = CV_DAYS;
                end
            end
            CV_DAYS:  state_next = CV_SPLIT;
            CV_SPLIT: state_next = CV_DIV1;
            CV_DIV1:  state_next = CV_YOE;
            CV_YOE:   state_next = CV_DOY;
            CV_DOY:   state_next = CV_MP;
            CV_MP:    state_next = CV_MDAY;
            CV_MDAY:  state_next = CV_YEAR;
            CV_YEAR:  state_next = CV_Y100;
            CV_Y100:  state_next = CV_YR;
            CV_YR:    state_next = CV_YDAY;
            CV_YDAY:  state_next = CV_PACK;
            CV_PACK:  state_next = CV_IDLE;
            default:  state_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
            epoch_reg <= 32'd0;
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        logic [1:0]  hund;
        logic [6:0]  rest;
        case (state_reg)
            CV_DAYS: days_reg <= days_prod[50:35];
            CV_SPLIT: begin
                secs_reg <= secs_full[16:0];
                era_reg  <= era5 ? 3'd5 : 3'd4;
                doe_reg  <= doe_full[17:0];
                wq_reg   <= wq_prod[31:19];
            end
            CV_DIV1: begin
                hour_reg <= hour_prod[24:20];
                wday_reg <= wday_full[2:0];
                a_reg    <= a_prod[30:24];
                b_reg    <= b_calc;
                c_reg    <= (doe_reg == 18'd146096);
            end
            CV_YOE: begin
                t_reg   <= t_full[11:0];
                yoe_reg <= yoe_prod[32:24];
            end
            CV_DOY: begin
                min_reg <= min_prod[19:14];
                doy_reg <= doy_full[8:0];
            end
            CV_MP: begin
                sec_reg <= sec_full[5:0];
                mp_reg  <= mp_prod[21:18];
                if (hour_reg >= 5'd12) begin
                    h12_reg <= (hour_reg == 5'd12) ? 4'd12 : 4'(hour_reg - 5'd12);
                end else begin
                    h12_reg <= (hour_reg == 5'd0) ? 4'd12 : 4'(hour_reg);
                end
            end
            CV_MDAY: begin
                mday_reg  <= mday_full[4:0];
                month_reg <= (mp_reg < 4'd10) ? (mp_reg + 4'd3) : (mp_reg - 4'd9);
            end
            CV_YEAR: year_reg  <= year_calc;
            CV_Y100: yq100_reg <= yq_prod[19:15];
            CV_YR:   yr100_reg <= yr_full[6:0];
            CV_YDAY: begin
                yday1_reg <= cum_days(month_reg) + 9'(mday_reg)
                           + (((month_reg > 4'd2) && leap) ? 9'd1 : 9'd0);
            end
            CV_PACK: begin
                if (yday1_reg >= 9'd300) begin
                    hund = 2'd3;
                end else if (yday1_reg >= 9'd200) begin
                    hund = 2'd2;
                end else if (yday1_reg >= 9'd100) begin
                    hund = 2'd1;
                end else begin
                    hund = 2'd0;
                end
                rest = 7'(yday1_reg - 9'(hund) * 9'd100);
                civil_reg.yr_hi   <= dec2(7'(yq100_reg));
                civil_reg.yr_lo   <= dec2(yr100_reg);
                civil_reg.mon     <= dec2(7'(month_reg));
                civil_reg.mday    <= dec2(7'(mday_reg));
                civil_reg.hour    <= dec2(7'(hour_reg));
                civil_reg.min     <= dec2(7'(min_reg));
                civil_reg.sec     <= dec2(7'(sec_reg));
                civil_reg.h12     <= dec2(7'(h12_reg));
                civil_reg.yday_h  <= 8'h30 + 8'(hund);
                civil_reg.yday_lo <= dec2(rest);
                civil_reg.wday    <= wday_reg;
                civil_reg.mon_idx <= month_reg - 4'd1;
                civil_reg.pm      <= (hour_reg >= 5'd12);
            end
            default: ;
        endcase
    end

endmodule

[src/etf_front.sv]
// etf_front: accepts format characters, tracks a pending '%', and queues commands.
// Uses etf_pkg command types.
`timescale 1ns / 1ps
module etf_front
    import etf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic       fifo_full,
    input  logic       busy,
    input  logic       epoch_zero,
    output logic       push,
    output cmd_t       cmd
);

    logic pend_reg, pend_next;
    logic accept;
    logic pend_eff;

    assign s_tready = !busy && !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign pend_eff = s_tuser[0] ? 1'b0 : pend_reg;

    always_comb begin
        pend_next = pend_reg;
        push      = 1'b0;
        cmd.kind  = CMD_LIT;
        cmd.ch    = s_tdata;
        if (accept) begin
            pend_next = pend_eff;
            if (epoch_zero) begin
                if (s_tuser[0]) begin
                    push     = 1'b1;
                    cmd.kind = CMD_ZERO;
                end
            end else if (s_tdata == CH_NUL) begin
                pend_next = 1'b0;
            end else if (pend_eff) begin
                pend_next = 1'b0;
                push      = 1'b1;
                cmd.kind  = CMD_SPEC;
            end else if (s_tdata == CH_PCT) begin
                pend_next = 1'b1;
            end else begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

[src/etf_cmd_fifo.sv]
// etf_cmd_fifo: short command queue between the front and the back.
// Depth from etf_pkg.
`timescale 1ns / 1ps
module etf_cmd_fifo
    import etf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic valid,
    output logic full,
    output cmd_t pop_cmd
);

    cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, rd_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;

    assign valid   = (cnt_reg != '0);
    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_cmd = mem[rd_reg];

    function automatic logic [FIFO_PTR_W-1:0] bump(input logic [FIFO_PTR_W-1:0] p);
        bump = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= bump(wr_reg);
            end
            if (pop) begin
                rd_reg <= bump(rd_reg);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[src/etf_back.sv]
// etf_back: expands one queued command into its character run and streams it out.
// Uses etf_pkg types, digit pairs and name tables.
`timescale 1ns / 1ps
module etf_back
    import etf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  civil_t     civil,
    input  logic       fifo_valid,
    input  cmd_t       fifo_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] txt;
        logic [LEN_W-1:0]        len;
    } run_t;

    localparam logic [7:0] SP_Y  = "Y";
    localparam logic [7:0] SP_YL = "y";
    localparam logic [7:0] SP_M  = "m";
    localparam logic [7:0] SP_D  = "d";
    localparam logic [7:0] SP_H  = "H";
    localparam logic [7:0] SP_MI = "M";
    localparam logic [7:0] SP_S  = "S";
    localparam logic [7:0] SP_A  = "a";
    localparam logic [7:0] SP_AF = "A";
    localparam logic [7:0] SP_B  = "b";
    localparam logic [7:0] SP_HB = "h";
    localparam logic [7:0] SP_BF = "B";
    localparam logic [7:0] SP_J  = "j";
    localparam logic [7:0] SP_P  = "p";
    localparam logic [7:0] SP_DF = "D";
    localparam logic [7:0] SP_F  = "F";
    localparam logic [7:0] SP_T  = "T";
    localparam logic [7:0] SP_R  = "r";
    localparam logic [7:0] SP_N  = "n";
    localparam logic [7:0] SP_TB = "t";
    localparam logic [7:0] SP_Z  = "Z";

    function automatic run_t build(input cmd_t c, input civil_t cv);
        run_t  r;
        name_t nm;
        logic [7:0] ap;
        r.txt = '0;
        r.len = LEN_W'(1);
        ap = cv.pm ? "P" : "A";
        nm = cv.pm ? day_name(cv.wday) : day_name(cv.wday);
        case (c.kind)
            CMD_LIT: r.txt[0] = c.ch;
            CMD_ZERO: begin
                for (int i = 0; i < RUN_MAX; i++) begin
                    r.txt[i] = ZERO_TEXT[RUN_MAX-1-i];
                end
                r.len = LEN_W'(RUN_MAX);
            end
            CMD_SPEC: begin
                case (c.ch)
                    SP_Y: begin
                        r.txt[3:0] = {cv.yr_lo[1], cv.yr_lo[0], cv.yr_hi[1], cv.yr_hi[0]};
                        r.len = LEN_W'(4);
                    end
                    SP_YL: begin r.txt[1:0] = {cv.yr_lo[1], cv.yr_lo[0]}; r.len = LEN_W'(2); end
                    SP_M:  begin r.txt[1:0] = {cv.mon[1], cv.mon[0]};     r.len = LEN_W'(2); end
                    SP_D:  begin r.txt[1:0] = {cv.mday[1], cv.mday[0]};   r.len = LEN_W'(2); end
                    SP_H:  begin r.txt[1:0] = {cv.hour[1], cv.hour[0]};   r.len = LEN_W'(2); end
                    SP_MI: begin r.txt[1:0] = {cv.min[1], cv.min[0]};     r.len = LEN_W'(2); end
                    SP_S:  begin r.txt[1:0] = {cv.sec[1], cv.sec[0]};     r.len = LEN_W'(2); end
                    SP_A, SP_AF: begin
                        nm = day_name(cv.wday);
                        for (int i = 0; i < 9; i++) begin
                            r.txt[i] = nm.txt[8-i];
                        end
                        r.len = (c.ch == SP_A) ? LEN_W'(3) : LEN_W'(nm.len);
                        if (c.ch == SP_A) begin
                            r.txt[8:3] = '0;
                        end
                    end
                    SP_B, SP_HB, SP_BF: begin
                        nm = mon_name(cv.mon_idx);
                        for (int i = 0; i < 9; i++) begin
                            r.txt[i] = nm.txt[8-i];
                        end
                        r.len = (c.ch == SP_BF) ? LEN_W'(nm.len) : LEN_W'(3);
                    end
                    SP_J: begin
                        r.txt[2:0] = {cv.yday_lo[1], cv.yday_lo[0], cv.yday_h};
                        r.len = LEN_W'(3);
                    end
                    SP_P: begin r.txt[1:0] = {8'h4D, ap}; r.len = LEN_W'(2); end
                    SP_DF: begin
                        r.txt[7:0] = {cv.yr_lo[1], cv.yr_lo[0], 8'h2F, cv.mday[1],
                                      cv.mday[0], 8'h2F, cv.mon[1], cv.mon[0]};
                        r.len = LEN_W'(8);
                    end
                    SP_F: begin
                        r.txt[9:0] = {cv.mday[1], cv.mday[0], 8'h2D, cv.mon[1], cv.mon[0],
                                      8'h2D, cv.yr_lo[1], cv.yr_lo[0], cv.yr_hi[1],
                                      cv.yr_hi[0]};
                        r.len = LEN_W'(10);
                    end
                    SP_T: begin
                        r.txt[7:0] = {cv.sec[1], cv.sec[0], 8'h3A, cv.min[1], cv.min[0],
                                      8'h3A, cv.hour[1], cv.hour[0]};
                        r.len = LEN_W'(8);
                    end
                    SP_R: begin
                        r.txt[10:0] = {8'h4D, ap, 8'h20, cv.sec[1], cv.sec[0], 8'h3A,
                                       cv.min[1], cv.min[0], 8'h3A, cv.h12[1], cv.h12[0]};
                        r.len = LEN_W'(11);
                    end
                    SP_N:   r.txt[0] = 8'h0A;
                    SP_TB:  r.txt[0] = 8'h09;
                    CH_PCT: r.txt[0] = CH_PCT;
                    SP_Z: begin r.txt[2:0] = {8'h43, 8'h54, 8'h55}; r.len = LEN_W'(3); end
                    default: begin
                        // unknown specifier echoes the percent and the character
                        r.txt[1:0] = {c.ch, CH_PCT};
                        r.len = LEN_W'(2);
                    end
                endcase
            end
            default: r.txt[0] = c.ch;
        endcase
        build = r;
    endfunction

    logic [RUN_MAX-1:0][7:0] buf_reg;
    logic [LEN_W-1:0]        cnt_reg;
    logic                    act_reg;
    logic                    take;
    logic                    is_last;
    run_t                    run;

    assign take     = act_reg && m_tready;
    assign is_last  = (cnt_reg == LEN_W'(1));
    assign pop      = fifo_valid && (!act_reg || (take && is_last));
    assign run      = build(fifo_cmd, civil);
    assign m_tvalid = act_reg;
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (pop) begin
            act_reg <= 1'b1;
            cnt_reg <= run.len;
        end else if (take) begin
            act_reg <= !is_last;
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            buf_reg <= run.txt;
        end else if (take) begin
            buf_reg <= {8'h00, buf_reg[RUN_MAX-1:1]};
        end
    end

endmodule

[src/epoch_time_format_stream_core.sv]
// epoch_time_format_stream_core: top level of the streaming epoch time formatter.
// Instantiates etf_civil, etf_front, etf_cmd_fifo and etf_back; uses etf_pkg.
//
// Usage:
//  - cfg_valid/cfg_ready/cfg_data writes the 32-bit seconds count. After each
//    write the civil converter walks the days-to-civil steps with reciprocal
//    multiplies; s_tready and cfg_ready stay low until it is done.
//  - s_* carries format characters; each request is one character plus the
//    start-of-format flag in tuser. The front classifies it and queues a
//    command; characters that produce nothing (a '%', a NUL) just update state.
//  - m_* streams the output characters one per cycle while m_tready is high;
//    tlast marks the last character of the run caused by one input request.
//  - An accepted input passes through the command queue and the output shifter
//    before its first output character. The back end's one-character-a-cycle
//    shifter sends one output character per cycle while m_tready is high; a
//    request yields 1 for a literal, up to 11 for %r, 24 for the zero-count string.
//  - A stalled receiver holds the run in the output shifter; the two-entry
//    command queue keeps taking input until it fills.
//  - Reset clears the count to zero, the pending percent, queue and output.
`timescale 1ns / 1ps
module epoch_time_format_stream_core
    import etf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write: seconds count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,     // [31:0] epoch_seconds
    // format characters in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] fmt_char
    input  logic [0:0]  s_tuser,      // [0] start_of_format
    // formatted characters out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] out_char
    output logic        m_tlast       // last_of_run
);

    civil_t civil;
    logic   busy;
    logic   epoch_zero;
    logic   push;
    cmd_t   push_cmd;
    logic   pop;
    logic   fifo_valid;
    logic   fifo_full;
    cmd_t   pop_cmd;

    // epoch register plus the calendar converter
    etf_civil u_civil (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .busy       (busy),
        .epoch_zero (epoch_zero),
        .civil      (civil)
    );

    // input side: pending-percent tracking and classification
    etf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_full  (fifo_full),
        .busy       (busy),
        .epoch_zero (epoch_zero),
        .push       (push),
        .cmd        (push_cmd)
    );

    etf_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .valid    (fifo_valid),
        .full     (fifo_full),
        .pop_cmd  (pop_cmd)
    );

    // output side: expansion and character shifter
    etf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .civil      (civil),
        .fifo_valid (fifo_valid),
        .fifo_cmd   (pop_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // a config write always starts a conversion
    a_cfg_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> busy)
        else $error("config write did not start conversion");

    // no input is taken while the converter runs
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (!s_tready && !push))
        else $error("input accepted during conversion");

    // a queued command never lands in a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_full)
        else $error("command queue overflow");

    // a zero-count start request is visible downstream in the next cycle
    a_zero_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && epoch_zero && s_tuser[0]) |=> (fifo_valid || m_tvalid))
        else $error("zero-count run lost");

endmodule
